### sv/spsu_pkg.sv
// shared types and constants for the sparse polynomial subtract unit
package spsu_pkg;

    localparam int COEF_W = 16;
    localparam int EXPO_W = 10;
    localparam int DIFF_W = 17;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // one stored term, coefficient in the low bits
    typedef struct packed {
        logic        [EXPO_W-1:0] expo;
        logic signed [COEF_W-1:0] coef;
    } term_t;

    localparam int TERM_W = $bits(term_t);

endpackage

### sv/spsu_ram.sv
// generic single-write, single-read ram with registered read data
module spsu_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sparse_polynomial_subtract_unit.sv
// top level of the sparse polynomial subtract unit: term load, merge and result output
//
// Two term lists, A and B, each up to TERMS_PER_LIST deep, sit in two small
// rams. A load beat (tuser = load A / load B) writes one term at the list's
// fill count; a load into a full list is dropped and sets a sticky overflow
// flag that is reported on every result of the next compute. A compute beat
// starts the merge: a start state issues the first ram reads, then one merge
// step per cycle unless the output stalls, each step consuming the head of A,
// of B or of both (equal exponents subtract, a zero difference is dropped,
// B-only terms are negated), plus a closing step. The rate is set by the single
// read port of each list ram, which gives one head per list per cycle. Each
// result is held in a pending register until the next one is found, so that
// the final one can be marked with tlast; when everything cancels or no term
// is loaded, one empty-marked result with zero data is sent. The output register
// lets the merge run on while a result waits; a stalled output freezes the merge
// only when a result must move to the output. Compute empties both lists
// and clears the overflow flag. Unused command code 3 is accepted and ignored.
module sparse_polynomial_subtract_unit #(
    parameter int TERMS_PER_LIST = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // term_coef[15:0], term_expo[25:16], zero pad
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // diff_coef[16:0], diff_expo[26:17], zero pad
    output logic        m_axis_tlast,   // is_last
    output logic [1:0]  m_axis_tuser    // is_empty[0], load_overflow[1]
);

    localparam int CntW  = $clog2(TERMS_PER_LIST + 1);
    localparam int AddrW = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
    localparam logic [CntW-1:0] Full = CntW'(TERMS_PER_LIST);

    localparam int CW = spsu_pkg::COEF_W;
    localparam int EW = spsu_pkg::EXPO_W;
    localparam int DW = spsu_pkg::DIFF_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_START = 3'b010,
        ST_MERGE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CntW-1:0]   a_cnt_reg, a_cnt_next;
    logic [CntW-1:0]   b_cnt_reg, b_cnt_next;
    logic [CntW-1:0]   i_reg, i_next;
    logic [CntW-1:0]   j_reg, j_next;
    logic              ovf_reg, ovf_next;

    // pending result, one result behind the merge
    logic              pend_valid_reg, pend_valid_next;
    logic signed [DW-1:0] pend_coef_reg, pend_coef_next;
    logic [EW-1:0]     pend_expo_reg, pend_expo_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic signed [DW-1:0] out_coef_reg, out_coef_next;
    logic [EW-1:0]     out_expo_reg, out_expo_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_ovf_reg, out_ovf_next;

    // input beat decode
    spsu_pkg::cmd_t    cmd;
    spsu_pkg::term_t   in_term;
    logic              in_accept;

    // ram ports
    logic              a_we, b_we;
    logic [AddrW-1:0]  a_raddr, b_raddr;
    spsu_pkg::term_t   a_rd, b_rd;

    // merge step
    logic              a_has, b_has, take_a, take_b, done;
    logic signed [DW-1:0] a_ext, b_ext, cand_coef;
    logic [EW-1:0]     cand_expo;
    logic              cand_valid, slot_free, stall, step, push;

    assign cmd             = spsu_pkg::cmd_t'(s_axis_tuser);
    assign in_term.coef    = s_axis_tdata[CW-1:0];
    assign in_term.expo    = s_axis_tdata[CW+EW-1:CW];
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign in_accept       = s_axis_tvalid && s_axis_tready;

    assign a_we = in_accept && (cmd == spsu_pkg::CMD_LOAD_A) && (a_cnt_reg < Full);
    assign b_we = in_accept && (cmd == spsu_pkg::CMD_LOAD_B) && (b_cnt_reg < Full);

    // read address follows the next head so data is ready on the next step
    assign a_raddr = (state_reg == ST_MERGE) ? i_next[AddrW-1:0] : '0;
    assign b_raddr = (state_reg == ST_MERGE) ? j_next[AddrW-1:0] : '0;

    spsu_ram #(
        .WIDTH (spsu_pkg::TERM_W),
        .DEPTH (TERMS_PER_LIST)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_cnt_reg[AddrW-1:0]),
        .wdata (in_term),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    spsu_ram #(
        .WIDTH (spsu_pkg::TERM_W),
        .DEPTH (TERMS_PER_LIST)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_cnt_reg[AddrW-1:0]),
        .wdata (in_term),
        .raddr (b_raddr),
        .rdata (b_rd)
    );

    // merge decision on the two list heads
    always_comb
    begin
        a_has = (i_reg < a_cnt_reg);
        b_has = (j_reg < b_cnt_reg);
        done  = !a_has && !b_has;
        take_a = a_has && (!b_has || (a_rd.expo >= b_rd.expo));
        take_b = b_has && (!a_has || (b_rd.expo >= a_rd.expo));
        a_ext = {a_rd.coef[CW-1], a_rd.coef};
        b_ext = {b_rd.coef[CW-1], b_rd.coef};
        if (take_a && take_b)
        begin
            cand_coef = a_ext - b_ext;
        end
        else if (take_a)
        begin
            cand_coef = a_ext;
        end
        else
        begin
            cand_coef = -b_ext;
        end
        cand_expo  = take_a ? a_rd.expo : b_rd.expo;
        // only a cancelled pair is dropped
        cand_valid = (take_a && take_b) ? (cand_coef != '0) : (take_a || take_b);
        slot_free  = !out_valid_reg || m_axis_tready;
        stall      = done ? !slot_free : (cand_valid && pend_valid_reg && !slot_free);
        step       = (state_reg == ST_MERGE) && !done && !stall;
        push       = (state_reg == ST_MERGE) && !stall
                     && (done || (cand_valid && pend_valid_reg));
        i_next     = (step && take_a) ? i_reg + 1'b1 : i_reg;
        j_next     = (step && take_b) ? j_reg + 1'b1 : j_reg;
    end

    // control and data path next state
    always_comb
    begin
        state_next      = state_reg;
        a_cnt_next      = a_cnt_reg;
        b_cnt_next      = b_cnt_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_expo_next  = pend_expo_reg;
        out_valid_next  = out_valid_reg;
        out_coef_next   = out_coef_reg;
        out_expo_next   = out_expo_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (cmd)
                        spsu_pkg::CMD_LOAD_A:
                        begin
                            if (a_we)
                            begin
                                a_cnt_next = a_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        spsu_pkg::CMD_LOAD_B:
                        begin
                            if (b_we)
                            begin
                                b_cnt_next = b_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        spsu_pkg::CMD_COMPUTE:
                        begin
                            state_next = ST_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_START:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (step && cand_valid)
                begin
                    pend_valid_next = 1'b1;
                    pend_coef_next  = cand_coef;
                    pend_expo_next  = cand_expo;
                end
                if (done && !stall)
                begin
                    pend_valid_next = 1'b0;
                    a_cnt_next      = '0;
                    b_cnt_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
            out_last_next  = done;
            out_ovf_next   = ovf_reg;
            if (done && !pend_valid_reg)
            begin
                out_coef_next  = '0;
                out_expo_next  = '0;
                out_empty_next = 1'b1;
            end
            else
            begin
                out_coef_next  = pend_coef_reg;
                out_expo_next  = pend_expo_reg;
                out_empty_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            a_cnt_reg      <= '0;
            b_cnt_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            a_cnt_reg      <= a_cnt_next;
            b_cnt_reg      <= b_cnt_next;
            // heads restart at zero for every compute
            i_reg          <= (state_reg == ST_IDLE) ? '0 : i_next;
            j_reg          <= (state_reg == ST_IDLE) ? '0 : j_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_coef_reg <= pend_coef_next;
        pend_expo_reg <= pend_expo_next;
        out_coef_reg  <= out_coef_next;
        out_expo_reg  <= out_expo_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32 - DW - EW){1'b0}}, out_expo_reg, out_coef_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_empty_reg};

endmodule

### sv/spsu_checker.sv
// port-level checks for the sparse polynomial subtract unit, bound to the top level
module spsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // an empty result carries zero data and closes its compute
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 32'd0) && m_axis_tlast)
        else $error("empty result with data or without last");

    // a real result keeps its padding bits clear
    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[31:27] == 5'd0))
        else $error("malformed result beat");

    // a compute beat makes the block busy in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == spsu_pkg::CMD_COMPUTE)
        |=> !s_axis_tready)
        else $error("input still ready after a compute beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sparse_polynomial_subtract_unit spsu_checker u_spsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sparse_polynomial_subtract_unit_test.sv
// self-checking testbench for the sparse polynomial subtract unit
module sparse_polynomial_subtract_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS_PER_LIST = 16;
    localparam int COEF_W         = spsu_pkg::COEF_W;
    localparam int EXPO_W         = spsu_pkg::EXPO_W;
    localparam int DIFF_W         = spsu_pkg::DIFF_W;
    // cycles with no beat on either side before the run is declared hung
    localparam int IDLE_LIMIT     = 2000;
    // settling time after the last expected result
    localparam int TAIL_CYCLES    = 40;

    // one input beat as queued for the driver, with the idle cycles before it
    typedef struct {
        spsu_pkg::cmd_t    cmd;
        logic [COEF_W-1:0] coef;
        logic [EXPO_W-1:0] expo;
        int                gap;
    } beat_t;

    // one expected difference term
    typedef struct {
        logic signed [DIFF_W-1:0] coef;
        logic [EXPO_W-1:0]        expo;
        logic                     is_last;
        logic                     is_empty;
        logic                     load_overflow;
    } diff_term_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // term_coef[15:0], term_expo[25:16], zero pad
    logic [1:0]  s_axis_tuser = spsu_pkg::CMD_NONE; // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // diff_coef[16:0], diff_expo[26:17], zero pad
    logic        m_axis_tlast;         // is_last
    logic [1:0]  m_axis_tuser;         // is_empty[0], load_overflow[1]

    sparse_polynomial_subtract_unit #(
        .TERMS_PER_LIST(TERMS_PER_LIST)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow copy of the two term lists and the dropped-load flag
    // ------------------------------------------------------------------
    spsu_pkg::term_t a_list [TERMS_PER_LIST];
    spsu_pkg::term_t b_list [TERMS_PER_LIST];
    int              a_fill = 0;
    int              b_fill = 0;
    logic            dropped_load = 1'b0;
    diff_term_t      diff_expected [$];
    int              fail_count = 0;

    beat_t      pending [$];
    bit         tx_calm = 1'b0;  // sender runs back to back while set
    bit         rx_calm = 1'b0;  // receiver never stalls while set

    // idle cycles before a beat: a mix of none, short and long waits
    function automatic int pace(bit calm);
        if (calm)
            return 0;
        case ($urandom_range(3))
            0:       return 0;
            1:       return $urandom_range(2);
            default: return $urandom_range(16);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] any_coef();
        // small values around zero make cancellations likely
        if ($urandom_range(3) == 0)
            return COEF_W'($urandom_range(20) - 10);
        return COEF_W'($urandom);
    endfunction

    function automatic void queue_beat(spsu_pkg::cmd_t c, logic [COEF_W-1:0] coef,
                                       logic [EXPO_W-1:0] expo);
        pending.push_back('{cmd: c, coef: coef, expo: expo, gap: pace(tx_calm)});
    endfunction

    // A - B merge over the shadow lists, then both lists and the flag clear
    function automatic void merge_difference();
        diff_term_t               batch [$];
        int                       i;
        int                       j;
        logic signed [DIFF_W-1:0] d;
        i = 0;
        j = 0;
        while (i < a_fill || j < b_fill)
        begin
            if (i < a_fill && j < b_fill && a_list[i].expo == b_list[j].expo)
            begin
                d = $signed(a_list[i].coef) - $signed(b_list[j].coef);
                // a zero difference drops the term
                if (d != 0)
                    batch.push_back('{d, a_list[i].expo, 1'b0, 1'b0, dropped_load});
                i++;
                j++;
            end
            else if (i < a_fill && (j >= b_fill || a_list[i].expo > b_list[j].expo))
            begin
                d = $signed(a_list[i].coef);
                batch.push_back('{d, a_list[i].expo, 1'b0, 1'b0, dropped_load});
                i++;
            end
            else
            begin
                // term only in B goes out negated; -(-32768) still fits 17 bits
                d = -$signed(b_list[j].coef);
                batch.push_back('{d, b_list[j].expo, 1'b0, 1'b0, dropped_load});
                j++;
            end
        end
        // everything cancelled: one empty-marked beat with zero data
        if (batch.size() == 0)
            batch.push_back('{'0, '0, 1'b0, 1'b1, dropped_load});
        batch[batch.size() - 1].is_last = 1'b1;
        foreach (batch[k])
            diff_expected.push_back(batch[k]);
        a_fill = 0;
        b_fill = 0;
        dropped_load = 1'b0;
    endfunction

    function automatic void track_input(spsu_pkg::cmd_t c, logic [COEF_W-1:0] coef,
                                        logic [EXPO_W-1:0] expo);
        case (c)
            spsu_pkg::CMD_LOAD_A:
                if (a_fill < TERMS_PER_LIST)
                begin
                    a_list[a_fill] = {expo, coef};
                    a_fill++;
                end
                else
                begin
                    dropped_load = 1'b1;
                end
            spsu_pkg::CMD_LOAD_B:
                if (b_fill < TERMS_PER_LIST)
                begin
                    b_list[b_fill] = {expo, coef};
                    b_fill++;
                end
                else
                begin
                    dropped_load = 1'b1;
                end
            spsu_pkg::CMD_COMPUTE:
                merge_difference();
            default:
                ; // unused code, no effect
        endcase
    endfunction

    function automatic void check_result();
        diff_term_t               want;
        logic signed [DIFF_W-1:0] got_coef;
        logic [EXPO_W-1:0]        got_expo;
        got_coef = $signed(m_axis_tdata[DIFF_W-1:0]);
        got_expo = m_axis_tdata[DIFF_W+EXPO_W-1:DIFF_W];
        if (diff_expected.size() == 0)
        begin
            $error("result beat with nothing expected: coef %0d expo %0d",
                   got_coef, got_expo);
            fail_count++;
            return;
        end
        want = diff_expected.pop_front();
        if (got_coef !== want.coef)
        begin
            $error("diff_coef: expected %0d, got %0d", want.coef, got_coef);
            fail_count++;
        end
        if (got_expo !== want.expo)
        begin
            $error("diff_expo: expected %0d, got %0d", want.expo, got_expo);
            fail_count++;
        end
        if (m_axis_tlast !== want.is_last)
        begin
            $error("is_last: expected %0b, got %0b", want.is_last, m_axis_tlast);
            fail_count++;
        end
        if (m_axis_tuser[0] !== want.is_empty)
        begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, m_axis_tuser[0]);
            fail_count++;
        end
        if (m_axis_tuser[1] !== want.load_overflow)
        begin
            $error("load_overflow: expected %0b, got %0b",
                   want.load_overflow, m_axis_tuser[1]);
            fail_count++;
        end
    endfunction

    // one list pair with interleaved descending exponents, loaded in random order;
    // returns the number of load beats queued
    function automatic int build_pair(int ta, int tb, int extra_a, int extra_b);
        spsu_pkg::term_t   a_side [$];
        spsu_pkg::term_t   b_side [$];
        spsu_pkg::term_t   t;
        int                expo;
        int                stride;
        int                pick;
        int                loads;
        logic [COEF_W-1:0] c;
        expo   = (ta + tb > 10) ? 1023 : $urandom_range(1023);
        stride = 1 + 1023 / (ta + tb + 1);
        while ((a_side.size() < ta || b_side.size() < tb) && expo >= 0)
        begin
            if (a_side.size() < ta && b_side.size() < tb)
                pick = $urandom_range(2);   // 0 only A, 1 only B, 2 shared exponent
            else if (a_side.size() < ta)
                pick = 0;
            else
                pick = 1;
            c = any_coef();
            if (pick != 1)
                a_side.push_back({EXPO_W'(expo), c});
            if (pick != 0)
                // shared exponents cancel about a third of the time
                b_side.push_back({EXPO_W'(expo),
                                  ($urandom_range(2) == 0) ? c : any_coef()});
            expo -= $urandom_range(stride, 1);
        end
        loads = a_side.size() + b_side.size() + extra_a + extra_b;
        while (a_side.size() + b_side.size() != 0)
        begin
            if (b_side.size() == 0 || (a_side.size() != 0 && $urandom_range(1) == 1))
            begin
                t = a_side.pop_front();
                queue_beat(spsu_pkg::CMD_LOAD_A, t.coef, t.expo);
            end
            else
            begin
                t = b_side.pop_front();
                queue_beat(spsu_pkg::CMD_LOAD_B, t.coef, t.expo);
            end
        end
        // loads past a full list
        repeat (extra_a) queue_beat(spsu_pkg::CMD_LOAD_A, any_coef(), EXPO_W'($urandom));
        repeat (extra_b) queue_beat(spsu_pkg::CMD_LOAD_B, any_coef(), EXPO_W'($urandom));
        return loads;
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued beats, holding each until accepted
    // ------------------------------------------------------------------
    int idle_spent = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= spsu_pkg::CMD_NONE;
            idle_spent    <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (idle_spent < pending[0].gap)
            begin
                s_axis_tvalid <= 1'b0;
                idle_spent    <= idle_spent + 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, pending[0].expo, pending[0].coef};
                s_axis_tuser  <= pending[0].cmd;
                idle_spent    <= 0;
                void'(pending.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: tracks accepted input beats, checks result beats and
    // throttles the result side with random stalls
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            // predict first so results of this beat are queued before any check
            if (s_axis_tvalid && s_axis_tready)
                track_input(spsu_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[COEF_W-1:0],
                            s_axis_tdata[COEF_W+EXPO_W-1:COEF_W]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
                // switch between stalling and free-running stretches now and then
                if ($urandom_range(15) == 0)
                    rx_calm = !rx_calm;
                hold = pace(rx_calm);
                if (hold != 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left    <= hold;
                end
            end
            else if (stall_left > 1)
            begin
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left    <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles without any beat
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** sparse_polynomial_subtract_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int             issued;
        int             shape;
        int             ta;
        int             tb;
        int             spill;
        spsu_pkg::cmd_t c;

        // nothing loaded: one empty-marked beat
        queue_beat(spsu_pkg::CMD_COMPUTE, '0, '0);
        // unused command code, all data bits set
        queue_beat(spsu_pkg::CMD_NONE, '1, '1);
        // extreme coefficients at the extreme exponents
        queue_beat(spsu_pkg::CMD_LOAD_A, 16'h7FFF, 10'd1023);
        queue_beat(spsu_pkg::CMD_LOAD_A, 16'h8000, 10'd0);
        queue_beat(spsu_pkg::CMD_LOAD_B, 16'h8000, 10'd1023);    // 32767 - (-32768)
        for (int k = 1; k <= 14; k++)
            // B-only -32768 negates to +32768
            queue_beat(spsu_pkg::CMD_LOAD_B, (k == 7) ? 16'h8000 : any_coef(),
                       EXPO_W'(1000 - 60 * k));
        // -32768 - 32767, list B now full
        queue_beat(spsu_pkg::CMD_LOAD_B, 16'h7FFF, 10'd0);
        // dropped, raises overflow
        queue_beat(spsu_pkg::CMD_LOAD_B, 16'h1234, 10'd5);
        queue_beat(spsu_pkg::CMD_COMPUTE, '0, '0);
        // full cancellation
        queue_beat(spsu_pkg::CMD_LOAD_A, 16'd5, 10'd10);
        queue_beat(spsu_pkg::CMD_LOAD_B, 16'd5, 10'd10);
        queue_beat(spsu_pkg::CMD_COMPUTE, '1, '1);

        issued = 0;
        while (issued < 105)
        begin
            tx_calm = ($urandom_range(3) == 0);
            shape   = $urandom_range(19);
            if (shape < 2)
            begin
                // noise: any command, any data, exponents in no order
                repeat ($urandom_range(6, 1))
                begin
                    c = spsu_pkg::cmd_t'($urandom_range(3));
                    queue_beat(c, COEF_W'($urandom), EXPO_W'($urandom));
                    if (c != spsu_pkg::CMD_NONE)
                        issued++;
                end
            end
            else
            begin
                spill = 0;
                if (shape < 5)
                begin
                    ta = $urandom_range(16, 12);
                    tb = $urandom_range(16, 12);
                end
                else if (shape < 7)
                begin
                    // one list filled to the brim and then some
                    ta = $urandom_range(16);
                    tb = $urandom_range(16);
                    spill = $urandom_range(3, 1);
                end
                else
                begin
                    ta = $urandom_range(5);
                    tb = $urandom_range(5);
                end
                if (spill != 0 && $urandom_range(1) == 0)
                    issued += build_pair(TERMS_PER_LIST, tb, spill, 0);
                else if (spill != 0)
                    issued += build_pair(ta, TERMS_PER_LIST, 0, spill);
                else
                    issued += build_pair(ta, tb, 0, 0);
                if ($urandom_range(9) == 0)
                    queue_beat(spsu_pkg::CMD_NONE, COEF_W'($urandom), EXPO_W'($urandom));
                queue_beat(spsu_pkg::CMD_COMPUTE, COEF_W'($urandom), EXPO_W'($urandom));
                issued++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || diff_expected.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** sparse_polynomial_subtract_unit: PASSED **");
        else
            $display("** sparse_polynomial_subtract_unit: FAILED **");
        $finish;
    end

endmodule

### sparse_polynomial_subtract_unit.f
sv/spsu_pkg.sv
sv/spsu_ram.sv
sv/sparse_polynomial_subtract_unit.sv
sv/spsu_checker.sv
tb/sparse_polynomial_subtract_unit_test.sv
